/* rtl/lhr_pkg.sv */
package lhr_pkg;

    // Histogram geometry
    localparam int NUM_BUCKETS  = 155;
    localparam int COUNTER_BITS = 32;
    localparam int NUM_BOUNDS   = 153;
    localparam int ADDR_W       = $clog2(NUM_BUCKETS);
    localparam int BIDX_W       = $clog2(NUM_BOUNDS + 1);

    // Field widths
    localparam int VAL_W     = 64;
    localparam int IDX_W     = 8;
    localparam int CNT_OUT_W = 32;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OUTST_W    = $clog2(FIFO_DEPTH + 1);

    // Request codes
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [VAL_W-1:0] sample_value;
        logic [IDX_W-1:0] bucket_select;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]     bucket_index;
        logic [CNT_OUT_W-1:0] bucket_count;
        logic [VAL_W-1:0]     min_value;
        logic [VAL_W-1:0]     max_value;
        logic [VAL_W-1:0]     total_sum;
        logic [VAL_W-1:0]     sample_count;
    } rsp_t;

    // Counter store commands
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_cmd_t;

    typedef struct packed {
        logic              en;
        logic              incr;
        logic [ADDR_W-1:0] addr;
    } commit_t;

    // Bucket boundaries, ascending; bucket = number of boundaries below the sample
    localparam logic [VAL_W-1:0] BOUNDS [NUM_BOUNDS] = '{
        64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
        64'd12, 64'd14, 64'd16, 64'd18, 64'd20, 64'd25, 64'd30, 64'd35,
        64'd40, 64'd45, 64'd50, 64'd60, 64'd70, 64'd80, 64'd90, 64'd100,
        64'd120, 64'd140, 64'd160, 64'd180, 64'd200, 64'd250, 64'd300, 64'd350,
        64'd400, 64'd450, 64'd500, 64'd600, 64'd700, 64'd800, 64'd900, 64'd1000,
        64'd1200, 64'd1400, 64'd1600, 64'd1800, 64'd2000, 64'd2500, 64'd3000,
        64'd3500, 64'd4000, 64'd4500, 64'd5000, 64'd6000, 64'd7000, 64'd8000,
        64'd9000, 64'd10000,
        64'd12000, 64'd14000, 64'd16000, 64'd18000, 64'd20000, 64'd25000,
        64'd30000, 64'd35000, 64'd40000, 64'd45000, 64'd50000, 64'd60000,
        64'd70000, 64'd80000, 64'd90000, 64'd100000,
        64'd120000, 64'd140000, 64'd160000, 64'd180000, 64'd200000, 64'd250000,
        64'd300000, 64'd350000, 64'd400000, 64'd450000, 64'd500000, 64'd600000,
        64'd700000, 64'd800000, 64'd900000, 64'd1000000,
        64'd1200000, 64'd1400000, 64'd1600000, 64'd1800000, 64'd2000000,
        64'd2500000, 64'd3000000, 64'd3500000, 64'd4000000, 64'd4500000,
        64'd5000000, 64'd6000000, 64'd7000000, 64'd8000000, 64'd9000000,
        64'd10000000,
        64'd12000000, 64'd14000000, 64'd16000000, 64'd18000000, 64'd20000000,
        64'd25000000, 64'd30000000, 64'd35000000, 64'd40000000, 64'd45000000,
        64'd50000000, 64'd60000000, 64'd70000000, 64'd80000000, 64'd90000000,
        64'd100000000,
        64'd120000000, 64'd140000000, 64'd160000000, 64'd180000000,
        64'd200000000, 64'd250000000, 64'd300000000, 64'd350000000,
        64'd400000000, 64'd450000000, 64'd500000000, 64'd600000000,
        64'd700000000, 64'd800000000, 64'd900000000, 64'd1000000000,
        64'd1200000000, 64'd1400000000, 64'd1600000000, 64'd1800000000,
        64'd2000000000, 64'd2500000000, 64'd3000000000, 64'd3500000000,
        64'd4000000000, 64'd4500000000, 64'd5000000000, 64'd6000000000,
        64'd7000000000, 64'd8000000000, 64'd9000000000
    };

endpackage

/* rtl/lhr_if.sv */
// Request channel
interface lhr_req_if;
    logic          valid;
    logic          ready;
    lhr_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface lhr_rsp_if;
    logic          valid;
    logic          ready;
    lhr_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/lhr_bucket_find.sv */
module lhr_bucket_find (
    input  logic                        clk,
    input  logic                        en,
    input  logic [lhr_pkg::VAL_W-1:0]   value,
    output logic [lhr_pkg::IDX_W-1:0]   bucket_idx
);

    logic [lhr_pkg::NUM_BOUNDS-1:0] therm_next;
    logic [lhr_pkg::NUM_BOUNDS-1:0] therm_reg;
    logic [lhr_pkg::BIDX_W-1:0]     count;

    // Compare against every boundary in parallel
    always_comb
    begin
        for (int i = 0; i < lhr_pkg::NUM_BOUNDS; i++)
        begin
            therm_next[i] = (value > lhr_pkg::BOUNDS[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            therm_reg <= therm_next;
        end
    end

    // Boundaries are sorted: the result is a thermometer code, take the top set bit
    always_comb
    begin
        count = '0;
        for (int i = 0; i < lhr_pkg::NUM_BOUNDS; i++)
        begin
            if (therm_reg[i])
            begin
                count = lhr_pkg::BIDX_W'(i + 1);
            end
        end
    end

    // Clamp to the last bucket
    always_comb
    begin
        if ({1'b0, count} > (lhr_pkg::BIDX_W + 1)'(lhr_pkg::NUM_BUCKETS - 1))
        begin
            bucket_idx = lhr_pkg::IDX_W'(lhr_pkg::NUM_BUCKETS - 1);
        end
        else
        begin
            bucket_idx = lhr_pkg::IDX_W'(count);
        end
    end

endmodule

/* rtl/lhr_counter_store.sv */
module lhr_counter_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lhr_pkg::rd_cmd_t                   rd_cmd,
    input  lhr_pkg::commit_t                   commit,
    output logic [lhr_pkg::COUNTER_BITS-1:0]   count
);

    logic [lhr_pkg::COUNTER_BITS-1:0] mem [lhr_pkg::NUM_BUCKETS];
    logic [lhr_pkg::COUNTER_BITS-1:0] rd_data_reg;
    logic [lhr_pkg::NUM_BUCKETS-1:0]  vld_reg;
    logic                             lw_vld_reg;
    logic [lhr_pkg::ADDR_W-1:0]       lw_addr_reg;
    logic [lhr_pkg::COUNTER_BITS-1:0] lw_data_reg;
    logic [lhr_pkg::COUNTER_BITS-1:0] cur;
    logic [lhr_pkg::COUNTER_BITS-1:0] incd;
    logic                             wr_en;

    assign wr_en = commit.en && commit.incr;

    // Counter memory: registered read, read-before-write
    always_ff @(posedge clk)
    begin
        if (rd_cmd.en)
        begin
            rd_data_reg <= mem[rd_cmd.addr];
        end
        if (wr_en)
        begin
            mem[commit.addr] <= incd;
        end
    end

    // Per-entry written flags; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            lw_vld_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            vld_reg[commit.addr] <= 1'b1;
            lw_vld_reg           <= 1'b1;
        end
    end

    // Last write, forwarded when the memory read missed it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_addr_reg <= commit.addr;
            lw_data_reg <= incd;
        end
    end

    always_comb
    begin
        if (lw_vld_reg && (lw_addr_reg == commit.addr))
        begin
            cur = lw_data_reg;
        end
        else if (vld_reg[commit.addr])
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    // Saturating increment
    assign incd  = (&cur) ? cur : cur + 1'b1;
    assign count = commit.incr ? incd : cur;

endmodule

/* rtl/lhr_out_fifo.sv */
module lhr_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lhr_pkg::rsp_t   push_data,
    lhr_rsp_if.source       rsp
);

    lhr_pkg::rsp_t                entries [lhr_pkg::FIFO_DEPTH];
    logic [lhr_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [lhr_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [lhr_pkg::OUTST_W-1:0]  fill_reg;
    logic                         pop;

    assign pop       = rsp.valid && rsp.ready;
    assign rsp.valid = (fill_reg != '0);
    assign rsp.data  = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + lhr_pkg::OUTST_W'(push) - lhr_pkg::OUTST_W'(pop);
        end
    end

endmodule

/* rtl/latency_histogram_recorder_core.sv */
// Latency histogram recorder.
// req channel: a record transfer (req_type 0) bins sample_value into one of
//   NUM_BUCKETS counters and updates running min, max, sum and count; a read
//   transfer (req_type 1) returns the counter at bucket_select.
// rsp channel: exactly one transfer per request, in request order, carrying
//   the bucket index, its counter after the update, and the running stats.
// Throughput: one request per cycle while req.ready is high. A request passes
//   through boundary compare, counter memory read and a read-modify-write
//   commit into the result queue, from which rsp delivers its result.
// Back-to-back updates of the same bucket are handled by forwarding the last
//   counter write, so no cycle is lost.
// Stalls: results collect in an 8-entry queue; req.ready stays high while
//   fewer than 8 requests are accepted but not yet delivered, so a stalled
//   receiver blocks new requests only once that queue would be full.
// Reset: asynchronous, active low. All counters read as zero, min is all
//   ones, max, sum and count are zero; no clearing pass is needed.
module latency_histogram_recorder_core (
    input  logic      clk,
    input  logic      rst_n,
    lhr_req_if.sink   req,
    lhr_rsp_if.source rsp
);

    logic                             in_fire;
    logic                             out_fire;
    logic [lhr_pkg::OUTST_W-1:0]      outst_reg;

    logic                             s1_valid_reg;
    logic                             s1_type_reg;
    logic [lhr_pkg::VAL_W-1:0]        s1_value_reg;
    logic [lhr_pkg::IDX_W-1:0]        s1_sel_reg;

    logic                             s2_valid_reg;
    logic                             s2_type_reg;
    logic                             s2_hit_reg;
    logic [lhr_pkg::VAL_W-1:0]        s2_value_reg;
    logic [lhr_pkg::IDX_W-1:0]        s2_idx_reg;

    logic [lhr_pkg::IDX_W-1:0]        rec_idx;
    logic [lhr_pkg::IDX_W-1:0]        s1_idx;
    logic                             s1_hit;
    lhr_pkg::rd_cmd_t                 rd_cmd;
    lhr_pkg::commit_t                 commit;
    logic [lhr_pkg::COUNTER_BITS-1:0] count;

    logic [lhr_pkg::VAL_W-1:0]        min_reg;
    logic [lhr_pkg::VAL_W-1:0]        max_reg;
    logic [lhr_pkg::VAL_W-1:0]        sum_reg;
    logic [lhr_pkg::VAL_W-1:0]        cnt_reg;
    logic [lhr_pkg::VAL_W-1:0]        min_next;
    logic [lhr_pkg::VAL_W-1:0]        max_next;
    logic [lhr_pkg::VAL_W-1:0]        sum_next;
    logic [lhr_pkg::VAL_W-1:0]        cnt_next;
    logic                             do_record;
    lhr_pkg::rsp_t                    push_data;

    // Credit against the result queue
    assign in_fire   = req.valid && req.ready;
    assign out_fire  = rsp.valid && rsp.ready;
    assign req.ready = (outst_reg < lhr_pkg::OUTST_W'(lhr_pkg::FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_reg + lhr_pkg::OUTST_W'(in_fire)
                         - lhr_pkg::OUTST_W'(out_fire);
        end
    end

    // Stage 1: boundary compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_type_reg  <= req.data.req_type;
            s1_value_reg <= req.data.sample_value;
            s1_sel_reg   <= req.data.bucket_select;
        end
    end

    lhr_bucket_find u_bucket_find (
        .clk        (clk),
        .en         (in_fire),
        .value      (req.data.sample_value),
        .bucket_idx (rec_idx)
    );

    // Stage 2: pick the address and read the counter
    always_comb
    begin
        if (s1_type_reg == lhr_pkg::REQ_READ)
        begin
            s1_idx = s1_sel_reg;
            s1_hit = ({1'b0, s1_sel_reg} < (lhr_pkg::IDX_W + 1)'(lhr_pkg::NUM_BUCKETS));
        end
        else
        begin
            s1_idx = rec_idx;
            s1_hit = 1'b1;
        end
    end

    assign rd_cmd.en   = s1_valid_reg && s1_hit;
    assign rd_cmd.addr = lhr_pkg::ADDR_W'(s1_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_type_reg  <= s1_type_reg;
            s2_hit_reg   <= s1_hit;
            s2_value_reg <= s1_value_reg;
            s2_idx_reg   <= s1_idx;
        end
    end

    // Stage 3: counter update and running stats
    assign do_record   = s2_valid_reg && (s2_type_reg == lhr_pkg::REQ_RECORD);
    assign commit.en   = s2_valid_reg && s2_hit_reg;
    assign commit.incr = (s2_type_reg == lhr_pkg::REQ_RECORD);
    assign commit.addr = lhr_pkg::ADDR_W'(s2_idx_reg);

    lhr_counter_store u_counter_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_cmd (rd_cmd),
        .commit (commit),
        .count  (count)
    );

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (do_record)
        begin
            if (s2_value_reg < min_reg)
            begin
                min_next = s2_value_reg;
            end
            if (s2_value_reg > max_reg)
            begin
                max_next = s2_value_reg;
            end
            sum_next = sum_reg + s2_value_reg;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    // Result assembly; an out-of-range read returns zero
    always_comb
    begin
        push_data.bucket_index = s2_idx_reg;
        push_data.bucket_count = s2_hit_reg ? lhr_pkg::CNT_OUT_W'(count) : '0;
        push_data.min_value    = min_next;
        push_data.max_value    = max_next;
        push_data.total_sum    = sum_next;
        push_data.sample_count = cnt_next;
    end

    lhr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .rsp       (rsp)
    );

endmodule
